>>> sv/pssu_pkg.sv
// Shared types and constants for the Potts site-update engine.
// No dependencies; the datapath, controller, core and testbench import this package.
`default_nettype none

package pssu_pkg;

    // Fixed field widths of the request and response words
    localparam int COORD_W   = 5;
    localparam int SPIN_W    = 8;
    localparam int COUNT_W   = 5;
    localparam int NSPIN_W   = 9;
    localparam int NBR_COUNT = 26;
    localparam int NBR_IDX_W = 5;

    localparam logic [NSPIN_W-1:0] NUM_SPINS_RESET = 9'd256;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_UPDATE = 2'd2,
        FUNC_ENERGY = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_COORD = 2'd1,
        ST_BAD_SPIN  = 2'd2
    } status_t;

    typedef struct packed {
        func_t               func;
        logic [COORD_W-1:0]  x_coord;
        logic [COORD_W-1:0]  y_coord;
        logic [COORD_W-1:0]  z_coord;
        logic [SPIN_W-1:0]   spin_value;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [SPIN_W-1:0]   site_spin;
        logic [COUNT_W-1:0]  old_like_count;
        logic [COUNT_W-1:0]  new_like_count;
        logic                accepted;
        logic [COUNT_W-1:0]  unlike_count;
    } rsp_t;

    typedef logic [NSPIN_W-1:0] cfg_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                 accept;
        logic                 calc_base;
        logic                 rd_center;
        logic                 rd_nbr;
        logic                 finish;
        logic [NBR_IDX_W-1:0] nbr_idx;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        func_t   func;
        status_t status;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/pssu_chan_if.sv
// Valid/ready channel carrying one payload word per handshake.
// The payload type is set by the instantiating level; no other dependencies.
`default_nettype none

interface pssu_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/pssu_dp.sv
// Datapath of the Potts site-update engine: lattice memory, address
// generation, neighbor counting and response register. Uses pssu_pkg.
`default_nettype none

module pssu_dp #(
    parameter int SIDE      = 16,
    parameter int SPIN_BITS = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pssu_pkg::req_t      req_data,
    input  wire logic                cfg_valid,
    input  wire pssu_pkg::cfg_word_t cfg_data,
    input  wire pssu_pkg::ctrl_cmd_t cmd,
    output pssu_pkg::dp_stat_t       stat,
    output pssu_pkg::rsp_t           rsp_data
);
    import pssu_pkg::*;

    localparam int DIM   = SIDE + 2;
    localparam int DEPTH = DIM * DIM * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = ((COORD_W > $clog2(DIM)) ? COORD_W : $clog2(DIM)) + 1;

    localparam logic [AW-1:0] DIM_A   = AW'(DIM);
    localparam logic [CW-1:0] SIDE_C  = CW'(SIDE);
    localparam logic [CW-1:0] HALO_HI = CW'(SIDE + 1);

    logic [SPIN_BITS-1:0] mem [DEPTH];

    logic [AW-1:0]        row_reg;
    logic [COORD_W-1:0]   z_reg;
    logic [AW-1:0]        base_reg;
    logic [SPIN_BITS-1:0] rd_data_reg;
    logic                 pend_center_reg;
    logic                 pend_nbr_reg;
    logic [SPIN_BITS-1:0] cur_reg;
    logic [SPIN_BITS-1:0] prop_reg;
    logic [COUNT_W-1:0]   nold_reg;
    logic [COUNT_W-1:0]   nnew_reg;
    func_t                func_reg;
    status_t              status_reg;
    cfg_word_t            num_spins_reg;
    rsp_t                 rsp_reg;

    logic [AW-1:0]        nbr_off [NBR_COUNT];
    logic [AW-1:0]        mem_addr;
    logic                 mem_rd;
    logic                 mem_wr;
    logic [CW-1:0]        xc;
    logic [CW-1:0]        yc;
    logic [CW-1:0]        zc;
    logic                 interior;
    logic                 in_range;
    status_t              status_next;
    logic                 upd_acc;
    rsp_t                 rsp_next;

    // Neighbor offsets in two's complement, center skipped
    for (genvar k = 0; k < NBR_COUNT; k++) begin : g_off
        localparam int J   = (k < NBR_COUNT / 2) ? k : k + 1;
        localparam int OFF = ((J / 9) - 1) * DIM * DIM + (((J / 3) % 3) - 1) * DIM
                             + ((J % 3) - 1);
        assign nbr_off[k] = AW'(OFF);
    end

    // Classify the incoming request
    assign xc = CW'(req_data.x_coord);
    assign yc = CW'(req_data.y_coord);
    assign zc = CW'(req_data.z_coord);
    assign interior = (xc >= CW'(1)) && (xc <= SIDE_C) && (yc >= CW'(1)) && (yc <= SIDE_C)
                      && (zc >= CW'(1)) && (zc <= SIDE_C);
    assign in_range = (xc <= HALO_HI) && (yc <= HALO_HI) && (zc <= HALO_HI);

    always_comb
    begin
        status_next = ST_OK;
        if ((req_data.func inside {FUNC_UPDATE, FUNC_ENERGY}) ? !interior : !in_range)
        begin
            status_next = ST_BAD_COORD;
        end
        else if ((req_data.func inside {FUNC_WRITE, FUNC_UPDATE})
                 && ({1'b0, req_data.spin_value} >= num_spins_reg))
        begin
            status_next = ST_BAD_SPIN;
        end
    end

    // Hold the spin-count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_spins_reg <= NUM_SPINS_RESET;
        end
        else if (cfg_valid)
        begin
            num_spins_reg <= cfg_data;
        end
    end

    // Latch the request and build the site address
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg    <= AW'(req_data.x_coord) * DIM_A + AW'(req_data.y_coord);
            z_reg      <= req_data.z_coord;
            prop_reg   <= SPIN_BITS'(req_data.spin_value);
            func_reg   <= req_data.func;
            status_reg <= status_next;
            nold_reg   <= '0;
            nnew_reg   <= '0;
        end
        else
        begin
            // Count neighbors equal to the old and the proposed spin
            if (pend_nbr_reg)
            begin
                if (rd_data_reg == cur_reg)
                begin
                    nold_reg <= nold_reg + COUNT_W'(1);
                end
                if (rd_data_reg == prop_reg)
                begin
                    nnew_reg <= nnew_reg + COUNT_W'(1);
                end
            end
        end
        if (cmd.calc_base)
        begin
            base_reg <= row_reg * DIM_A + AW'(z_reg);
        end
        if (pend_center_reg)
        begin
            cur_reg <= rd_data_reg;
        end
    end

    // Track what the read register holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_center_reg <= 1'b0;
            pend_nbr_reg    <= 1'b0;
        end
        else
        begin
            pend_center_reg <= cmd.rd_center;
            pend_nbr_reg    <= cmd.rd_nbr;
        end
    end

    // Lattice memory, one port
    assign mem_addr = cmd.rd_nbr ? (base_reg + nbr_off[cmd.nbr_idx]) : base_reg;
    assign mem_rd   = cmd.rd_center | cmd.rd_nbr;
    assign upd_acc  = (nold_reg <= nnew_reg);
    assign mem_wr   = cmd.finish && (status_reg == ST_OK)
                      && ((func_reg == FUNC_WRITE) || ((func_reg == FUNC_UPDATE) && upd_acc));

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[mem_addr] <= prop_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // Form the response word
    always_comb
    begin
        rsp_next = '0;
        rsp_next.status = status_reg;
        if (status_reg == ST_BAD_SPIN)
        begin
            rsp_next.site_spin = SPIN_W'(cur_reg);
        end
        else if (status_reg == ST_OK)
        begin
            case (func_reg)
                FUNC_WRITE:
                begin
                    rsp_next.site_spin = SPIN_W'(prop_reg);
                end
                FUNC_READ:
                begin
                    rsp_next.site_spin = SPIN_W'(cur_reg);
                end
                FUNC_UPDATE:
                begin
                    rsp_next.site_spin      = upd_acc ? SPIN_W'(prop_reg) : SPIN_W'(cur_reg);
                    rsp_next.old_like_count = nold_reg;
                    rsp_next.new_like_count = nnew_reg;
                    rsp_next.accepted       = upd_acc;
                    rsp_next.unlike_count   = COUNT_W'(NBR_COUNT)
                                              - (upd_acc ? nnew_reg : nold_reg);
                end
                FUNC_ENERGY:
                begin
                    rsp_next.site_spin      = SPIN_W'(cur_reg);
                    rsp_next.old_like_count = nold_reg;
                    rsp_next.unlike_count   = COUNT_W'(NBR_COUNT) - nold_reg;
                end
                default:
                begin
                    rsp_next.site_spin = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_data    = rsp_reg;
    assign stat.func   = func_reg;
    assign stat.status = status_reg;

endmodule

`default_nettype wire

>>> sv/pssu_ctrl.sv
// Controller of the Potts site-update engine: sequences address build,
// center and neighbor reads, and the result hand-off. Uses pssu_pkg.
`default_nettype none

module pssu_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    input  wire pssu_pkg::dp_stat_t stat,
    output pssu_pkg::ctrl_cmd_t     cmd
);
    import pssu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_CENTER,
        S_NBR,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [NBR_IDX_W-1:0] nbr_idx_reg;
    logic [NBR_IDX_W-1:0] nbr_idx_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 need_nbr;
    logic                 slot_free;

    assign need_nbr  = (stat.status == ST_OK) && (stat.func inside {FUNC_UPDATE, FUNC_ENERGY});
    assign slot_free = !out_valid_reg || rsp_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        nbr_idx_next   = nbr_idx_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd            = '0;
        cmd.nbr_idx    = nbr_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                cmd.calc_base = 1'b1;
                if ((stat.status == ST_BAD_COORD)
                    || ((stat.status == ST_OK) && (stat.func == FUNC_WRITE)))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_CENTER;
                end
            end
            S_CENTER:
            begin
                cmd.rd_center = 1'b1;
                nbr_idx_next  = '0;
                state_next    = need_nbr ? S_NBR : S_DRAIN;
            end
            S_NBR:
            begin
                cmd.rd_nbr   = 1'b1;
                nbr_idx_next = nbr_idx_reg + NBR_IDX_W'(1);
                if (nbr_idx_reg == NBR_IDX_W'(NBR_COUNT - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // Wait for the output slot, then commit and publish
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nbr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nbr_idx_reg   <= nbr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> sv/potts_site_update_3d_core.sv
// Zero-temperature 26-neighbor Potts site engine on a cubic lattice with halo.
// Three channels: req takes one operation word (write, read, update, energy),
// rsp returns one result word per request, cfg writes the spin-count register
// (always ready, write only while no operation is in flight).
// Steps per operation, after acceptance and the address step:
//   update / energy query: 27 lattice reads serialized on the one memory port, drain, finish
//   read, or write/update with a too-large spin: one center read, drain, finish
//   in-range write, or bad coordinate: finish
// The result word becomes valid in the same cycle in which the next request can
// be taken.
// The response sits in an output register: a new request is taken while it
// waits; a stalled receiver holds the next result in its finish step until
// the register frees, and the lattice write is made at that moment.
// Reset clears the control state and sets the spin count to 256; the lattice
// is not cleared and must be written by the host before it is read.
// Depends on pssu_pkg, pssu_chan_if, pssu_ctrl and pssu_dp.
`default_nettype none

module potts_site_update_3d_core #(
    parameter int SIDE      = 16,
    parameter int SPIN_BITS = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pssu_chan_if.sink   req,
    pssu_chan_if.source rsp,
    pssu_chan_if.sink   cfg
);
    import pssu_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Configuration is always accepted
    assign cfg.ready = 1'b1;

    pssu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pssu_dp #(
        .SIDE      (SIDE),
        .SPIN_BITS (SPIN_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req.data),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_data  (rsp.data)
    );

endmodule

`default_nettype wire

>>> sim/potts_site_update_3d_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for potts_site_update_3d_core: write/read/update/energy words
// are checked field by field against an in-bench site engine or written-out results.
// Depends on pssu_pkg, pssu_chan_if and the core with its submodules.

module potts_site_update_3d_core_tb;

    import pssu_pkg::*;

    localparam int SIDE         = 16;
    localparam int DIM          = SIDE + 2;
    localparam int CUBE         = 5;           // edge of a fully written working cube
    localparam int HI_CORNER    = DIM - CUBE;  // low corner of the upper working cube
    localparam int STALL_LIMIT  = 2000;        // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 40;
    localparam int OPS_PER_PHASE = 100;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_LIMITS [NUM_PHASES] = '{2, 4, 256, 1, 511, 3};

    typedef struct {
        bit        is_cfg;
        cfg_word_t cfg_value;
        req_t      op;
        bit        typed;
        rsp_t      want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    pssu_chan_if #(.payload_t(req_t))      req_ch ();
    pssu_chan_if #(.payload_t(rsp_t))      rsp_ch ();
    pssu_chan_if #(.payload_t(cfg_word_t)) cfg_ch ();

    // Bench copy of the block state
    logic [SPIN_W-1:0] lattice [0:DIM-1][0:DIM-1][0:DIM-1];
    cfg_word_t         num_spins_reg = NUM_SPINS_RESET;

    rsp_t     pending_results [$];
    dir_row_t directed_ops [$];
    int       spin_limit = 256;   // spin count the generator works with
    bit       idle_on = 1'b1;
    bit       op_typed;
    rsp_t     op_want;
    int       error_count = 0;
    int       result_count = 0;
    int       stall_cycles = 0;

    potts_site_update_3d_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_error(string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Count the 26 neighbors holding spin s
    function automatic int count_matching_neighbors(int x, int y, int z,
                                                    logic [SPIN_W-1:0] s);
        int n;
        int a;
        int b;
        int c;
        n = 0;
        for (a = x - 1; a <= x + 1; a++)
            for (b = y - 1; b <= y + 1; b++)
                for (c = z - 1; c <= z + 1; c++)
                    if (!(a == x && b == y && c == z) && lattice[a][b][c] == s)
                        n++;
        return n;
    endfunction

    // Apply one operation word to the bench lattice and return its result word
    function automatic rsp_t apply_site_op(req_t r);
        rsp_t              o;
        int                x;
        int                y;
        int                z;
        bit                interior;
        bit                in_range;
        logic [SPIN_W-1:0] cur;
        int                n_old;
        int                n_new;
        o = '0;
        x = r.x_coord;
        y = r.y_coord;
        z = r.z_coord;
        interior = x >= 1 && x <= SIDE && y >= 1 && y <= SIDE && z >= 1 && z <= SIDE;
        in_range = x <= SIDE + 1 && y <= SIDE + 1 && z <= SIDE + 1;
        if ((r.func == FUNC_UPDATE || r.func == FUNC_ENERGY) ? !interior : !in_range)
        begin
            o.status = ST_BAD_COORD;
            return o;
        end
        cur = lattice[x][y][z];
        o.status = ST_OK;
        o.site_spin = cur;
        if ((r.func == FUNC_WRITE || r.func == FUNC_UPDATE) && r.spin_value >= num_spins_reg)
        begin
            o.status = ST_BAD_SPIN;
            return o;
        end
        case (r.func)
            FUNC_WRITE:
            begin
                lattice[x][y][z] = r.spin_value;
                o.site_spin = r.spin_value;
            end
            FUNC_UPDATE:
            begin
                n_old = count_matching_neighbors(x, y, z, cur);
                n_new = count_matching_neighbors(x, y, z, r.spin_value);
                o.old_like_count = COUNT_W'(n_old);
                o.new_like_count = COUNT_W'(n_new);
                if (n_old <= n_new)
                begin
                    lattice[x][y][z] = r.spin_value;
                    o.site_spin = r.spin_value;
                    o.accepted = 1'b1;
                    o.unlike_count = COUNT_W'(NBR_COUNT - n_new);
                end
                else
                begin
                    o.unlike_count = COUNT_W'(NBR_COUNT - n_old);
                end
            end
            FUNC_ENERGY:
            begin
                n_old = count_matching_neighbors(x, y, z, cur);
                o.old_like_count = COUNT_W'(n_old);
                o.unlike_count = COUNT_W'(NBR_COUNT - n_old);
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic compare_result(rsp_t got, rsp_t want);
        if (got.status !== want.status)
            report_error($sformatf("result %0d: status %0d, expected %0d",
                                   result_count, got.status, want.status));
        if (got.site_spin !== want.site_spin)
            report_error($sformatf("result %0d: site_spin %0d, expected %0d",
                                   result_count, got.site_spin, want.site_spin));
        if (got.old_like_count !== want.old_like_count)
            report_error($sformatf("result %0d: old_like_count %0d, expected %0d",
                                   result_count, got.old_like_count, want.old_like_count));
        if (got.new_like_count !== want.new_like_count)
            report_error($sformatf("result %0d: new_like_count %0d, expected %0d",
                                   result_count, got.new_like_count, want.new_like_count));
        if (got.accepted !== want.accepted)
            report_error($sformatf("result %0d: accepted %0d, expected %0d",
                                   result_count, got.accepted, want.accepted));
        if (got.unlike_count !== want.unlike_count)
            report_error($sformatf("result %0d: unlike_count %0d, expected %0d",
                                   result_count, got.unlike_count, want.unlike_count));
    endtask

    // Watch all three channels: check results, predict accepted words, track config
    always @(posedge clk)
    begin : monitor
        bit   moved;
        rsp_t want;
        if (rst_n)
        begin
            moved = 1'b0;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                if (pending_results.size() == 0)
                begin
                    report_error($sformatf("result %0d arrived with nothing pending",
                                           result_count));
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_result(rsp_ch.data, want);
                end
                result_count++;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                moved = 1'b1;
                want = apply_site_op(req_ch.data);
                pending_results.push_back(op_typed ? op_want : want);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                moved = 1'b1;
                num_spins_reg = cfg_ch.data;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("potts_site_update_3d_core_tb: done, errors");
                $finish;
            end
        end
    end

    // Receiver: drop ready in short random bursts while idling is enabled
    initial
    begin : rsp_stall
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Offer one word, optionally after an idle burst, and hold it until taken
    task automatic send_op(req_t r, bit typed, rsp_t want);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        op_typed     <= typed;
        op_want      <= want;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Drain every pending result, then write the spin count
    task automatic set_num_spins(cfg_word_t value);
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        spin_limit = value;
    endtask

    function automatic logic [SPIN_W-1:0] legal_spin();
        if (spin_limit >= 256)
            return SPIN_W'($urandom_range(0, 255));
        return SPIN_W'($urandom_range(0, spin_limit - 1));
    endfunction

    // Write every site of one working cube
    task automatic fill_cube(int lo, bit zeros);
        req_t r;
        int   a;
        int   b;
        int   c;
        r.func = FUNC_WRITE;
        for (a = lo; a < lo + CUBE; a++)
            for (b = lo; b < lo + CUBE; b++)
                for (c = lo; c < lo + CUBE; c++)
                begin
                    r.x_coord = COORD_W'(a);
                    r.y_coord = COORD_W'(b);
                    r.z_coord = COORD_W'(c);
                    r.spin_value = zeros ? '0 : legal_spin();
                    send_op(r, 1'b0, '0);
                end
    endtask

    // Mostly well-formed work inside the written cubes, some bad spins and coordinates
    function automatic req_t random_site_op();
        req_t r;
        int   pick;
        int   lo;
        int   off_lo;
        int   off_hi;
        int   bad;
        pick = $urandom_range(0, 99);
        lo = ($urandom_range(0, 1) != 0) ? HI_CORNER : 0;
        off_lo = 0;
        off_hi = CUBE - 1;
        r.spin_value = legal_spin();
        if (pick < 20)
        begin
            r.func = FUNC_WRITE;
        end
        else if (pick < 25)
        begin
            r.func = FUNC_WRITE;
            lo = 0;
            off_hi = DIM - 1;
        end
        else if (pick < 35)
        begin
            r.func = FUNC_READ;
            r.spin_value = SPIN_W'($urandom_range(0, 255));
        end
        else if (pick < 75)
        begin
            r.func = FUNC_UPDATE;
            off_lo = 1;
            off_hi = CUBE - 2;
        end
        else if (pick < 87)
        begin
            r.func = FUNC_ENERGY;
            r.spin_value = SPIN_W'($urandom_range(0, 255));
            off_lo = 1;
            off_hi = CUBE - 2;
        end
        else if (pick < 93)
        begin
            r.func = ($urandom_range(0, 1) != 0) ? FUNC_UPDATE : FUNC_WRITE;
            if (spin_limit <= 255)
                r.spin_value = SPIN_W'($urandom_range(spin_limit, 255));
            if (r.func == FUNC_UPDATE)
            begin
                off_lo = 1;
                off_hi = CUBE - 2;
            end
        end
        r.x_coord = COORD_W'(lo + $urandom_range(off_lo, off_hi));
        r.y_coord = COORD_W'(lo + $urandom_range(off_lo, off_hi));
        r.z_coord = COORD_W'(lo + $urandom_range(off_lo, off_hi));
        if (pick >= 93)
        begin
            // Push one axis out of range, or onto the halo for interior-only operations
            r.func = func_t'($urandom_range(0, 3));
            r.spin_value = SPIN_W'($urandom_range(0, 255));
            r.x_coord = COORD_W'($urandom_range(0, DIM - 1));
            r.y_coord = COORD_W'($urandom_range(0, DIM - 1));
            r.z_coord = COORD_W'($urandom_range(0, DIM - 1));
            if ((r.func == FUNC_UPDATE || r.func == FUNC_ENERGY) && $urandom_range(0, 1) != 0)
                bad = ($urandom_range(0, 1) != 0) ? 0 : DIM - 1;
            else
                bad = $urandom_range(DIM, 31);
            case ($urandom_range(0, 2))
                0:       r.x_coord = COORD_W'(bad);
                1:       r.y_coord = COORD_W'(bad);
                default: r.z_coord = COORD_W'(bad);
            endcase
        end
        return r;
    endfunction

    function automatic void add_cfg(int value);
        dir_row_t row;
        row.is_cfg = 1'b1;
        row.cfg_value = NSPIN_W'(value);
        row.op = '0;
        row.typed = 1'b0;
        row.want = '0;
        directed_ops.push_back(row);
    endfunction

    function automatic void add_op(func_t f, int x, int y, int z, int s);
        dir_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_value = '0;
        row.op.func = f;
        row.op.x_coord = COORD_W'(x);
        row.op.y_coord = COORD_W'(y);
        row.op.z_coord = COORD_W'(z);
        row.op.spin_value = SPIN_W'(s);
        row.typed = 1'b0;
        row.want = '0;
        directed_ops.push_back(row);
    endfunction

    // Directed word with its result written out
    function automatic void add_checked(func_t f, int x, int y, int z, int s, status_t st,
                                        int spin, int n_old, int n_new, int acc, int unlike);
        add_op(f, x, y, z, s);
        directed_ops[$].typed = 1'b1;
        directed_ops[$].want.status = st;
        directed_ops[$].want.site_spin = SPIN_W'(spin);
        directed_ops[$].want.old_like_count = COUNT_W'(n_old);
        directed_ops[$].want.new_like_count = COUNT_W'(n_new);
        directed_ops[$].want.accepted = acc[0];
        directed_ops[$].want.unlike_count = COUNT_W'(unlike);
    endfunction

    initial
    begin : stimulus
        int p;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        op_typed     <= 1'b0;
        op_want      <= '0;
        rst_n        <= 1'b0;

        // Lower cube is all zero after the fill, upper cube random
        add_checked(FUNC_WRITE,  17, 17, 17, 255, ST_OK, 255, 0, 0, 0, 0);
        add_checked(FUNC_READ,   17, 17, 17, 0,   ST_OK, 255, 0, 0, 0, 0);
        add_checked(FUNC_READ,   0,  0,  0,  0,   ST_OK, 0,   0, 0, 0, 0);
        add_checked(FUNC_WRITE,  0,  17, 0,  128, ST_OK, 128, 0, 0, 0, 0);
        add_checked(FUNC_READ,   0,  17, 0,  0,   ST_OK, 128, 0, 0, 0, 0);
        add_checked(FUNC_ENERGY, 2,  2,  2,  0,   ST_OK, 0, 26, 0, 0, 0);
        add_checked(FUNC_UPDATE, 2,  2,  2,  7,   ST_OK, 0, 26, 0, 0, 0);
        // proposal equal to the held spin is taken
        add_checked(FUNC_UPDATE, 2,  2,  2,  0,   ST_OK, 0, 26, 26, 1, 0);
        add_checked(FUNC_WRITE,  18, 1,  1,  5,   ST_BAD_COORD, 0, 0, 0, 0, 0);
        add_checked(FUNC_READ,   1,  31, 1,  0,   ST_BAD_COORD, 0, 0, 0, 0, 0);
        add_checked(FUNC_UPDATE, 0,  2,  2,  1,   ST_BAD_COORD, 0, 0, 0, 0, 0);
        add_checked(FUNC_ENERGY, 2,  2,  17, 0,   ST_BAD_COORD, 0, 0, 0, 0, 0);
        add_op(FUNC_UPDATE, 16, 16, 16, 8'h55);
        add_op(FUNC_ENERGY, 16, 16, 16, 8'hAA);
        add_cfg(3);
        add_checked(FUNC_WRITE,  1,  1,  1,  3,   ST_BAD_SPIN, 0, 0, 0, 0, 0);
        add_checked(FUNC_UPDATE, 2,  2,  2,  200, ST_BAD_SPIN, 0, 0, 0, 0, 0);
        add_checked(FUNC_WRITE,  2,  2,  2,  2,   ST_OK, 2, 0, 0, 0, 0);
        add_checked(FUNC_ENERGY, 2,  2,  2,  0,   ST_OK, 2, 0, 0, 0, 26);
        add_checked(FUNC_UPDATE, 1,  1,  1,  2,   ST_OK, 0, 25, 1, 0, 1);
        add_checked(FUNC_UPDATE, 2,  2,  2,  0,   ST_OK, 0, 0, 26, 1, 0);
        // zero spin count rejects every spin
        add_cfg(0);
        add_checked(FUNC_WRITE,  3,  3,  3,  0,   ST_BAD_SPIN, 0, 0, 0, 0, 0);
        add_checked(FUNC_UPDATE, 3,  3,  3,  0,   ST_BAD_SPIN, 0, 0, 0, 0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill both working cubes so every later read hits written entries
        fill_cube(0, 1'b1);
        fill_cube(HI_CORNER, 1'b0);

        foreach (directed_ops[i])
        begin
            if (directed_ops[i].is_cfg)
                set_num_spins(directed_ops[i].cfg_value);
            else
                send_op(directed_ops[i].op, directed_ops[i].typed, directed_ops[i].want);
        end

        // Random phases, each under its own spin count; the last one runs without idling
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            set_num_spins(NSPIN_W'(PHASE_LIMITS[p]));
            if (spin_limit <= 16)
                fill_cube(($urandom_range(0, 1) != 0) ? HI_CORNER : 0, 1'b0);
            repeat (OPS_PER_PHASE) send_op(random_site_op(), 1'b0, '0);
        end

        // Drain and let the block settle
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("potts_site_update_3d_core_tb: done, clean");
        else
            $display("potts_site_update_3d_core_tb: done, errors");
        $finish;
    end

endmodule
